@@ sv/csc_pkg.sv @@
package csc_pkg;

  // Default window / pattern length
  localparam int unsigned PAT_LEN_DEFAULT = 64;

  // Field widths
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned PROD_W = 33;   // Q1.15 x Q1.15, two products summed
  localparam int unsigned CORR_W = 40;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // Saturation limits of the result
  localparam logic signed [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
  localparam logic signed [CORR_W-1:0] CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};

  typedef struct packed {
    logic signed [VAL_W-1:0] re;
    logic signed [VAL_W-1:0] im;
  } cplx_t;

  // Per-cycle controls broadcast along the cell row
  typedef struct packed {
    logic push;   // shift sample line by one cell
    logic conj;   // conjugate the taps
  } cell_ctrl_t;

endpackage

@@ sv/csc_cell.sv @@
module csc_cell #(
  parameter int unsigned ACC_W = 39
) (
  input  logic                    clk_i,
  input  csc_pkg::cell_ctrl_t     ctrl_i,
  input  logic                    tap_we_i,
  input  csc_pkg::cplx_t          tap_i,
  input  csc_pkg::cplx_t          smp_i,
  output csc_pkg::cplx_t          smp_o,
  input  logic signed [ACC_W-1:0] psum_re_i,
  input  logic signed [ACC_W-1:0] psum_im_i,
  output logic signed [ACC_W-1:0] psum_re_o,
  output logic signed [ACC_W-1:0] psum_im_o
);
  import csc_pkg::*;

  cplx_t                   smp_q;
  cplx_t                   tap_q;
  logic signed [VAL_W-1:0] a, b, c, d;
  logic signed [31:0]      ac, bd, ad, bc;
  logic signed [PROD_W-1:0] prod_re_d, prod_im_d;
  logic signed [PROD_W-1:0] prod_re_q, prod_im_q;
  logic signed [ACC_W-1:0]  psum_re_d, psum_im_d;
  logic signed [ACC_W-1:0]  psum_re_q, psum_im_q;

  assign a = smp_q.re;
  assign b = smp_q.im;
  assign c = tap_q.re;
  assign d = tap_q.im;

  always_comb begin
    ac = a * c;
    bd = b * d;
    ad = a * d;
    bc = b * c;
    if (ctrl_i.conj) begin
      prod_re_d = PROD_W'(ac) + PROD_W'(bd);
      prod_im_d = PROD_W'(bc) - PROD_W'(ad);
    end else begin
      prod_re_d = PROD_W'(ac) - PROD_W'(bd);
      prod_im_d = PROD_W'(bc) + PROD_W'(ad);
    end
    psum_re_d = psum_re_i + ACC_W'(prod_re_q);
    psum_im_d = psum_im_i + ACC_W'(prod_im_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      smp_q <= smp_i;
    end
    if (tap_we_i) begin
      tap_q <= tap_i;
    end
    prod_re_q <= prod_re_d;
    prod_im_q <= prod_im_d;
    psum_re_q <= psum_re_d;
    psum_im_q <= psum_im_d;
  end

  assign smp_o     = smp_q;
  assign psum_re_o = psum_re_q;
  assign psum_im_o = psum_im_q;

endmodule

@@ sv/csc_ctrl.sv @@
module csc_ctrl #(
  parameter int unsigned PATTERN_LEN = 64,
  parameter int unsigned ACC_W       = 39
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [csc_pkg::ACT_W-1:0] action_i,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i,
  output csc_pkg::cell_ctrl_t       cell_ctrl_o,
  output logic                      load_o,
  input  logic signed [ACC_W-1:0]   psum_re_i,
  input  logic signed [ACC_W-1:0]   psum_im_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [csc_pkg::CORR_W-1:0] corr_re_o,
  output logic signed [csc_pkg::CORR_W-1:0] corr_im_o
);
  import csc_pkg::*;

  localparam int unsigned FILL_W = $clog2(PATTERN_LEN + 1);
  localparam int unsigned CNT_W  = $clog2(PATTERN_LEN + 2);
  localparam int unsigned EXT_W  = (ACC_W > CORR_W) ? ACC_W : CORR_W;
  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(PATTERN_LEN);
  localparam logic [FILL_W-1:0] FILL_LAST  = FILL_W'(PATTERN_LEN - 1);
  // covers the product register, then each cell's partial-sum register in the ripple
  localparam logic [CNT_W-1:0]  CNT_START  = CNT_W'(PATTERN_LEN + 1);
  localparam logic signed [EXT_W-1:0] MAX_E = EXT_W'(CORR_MAX);
  localparam logic signed [EXT_W-1:0] MIN_E = EXT_W'(CORR_MIN);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic              state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              conj_q;
  logic              out_valid_q, out_valid_d;
  logic signed [CORR_W-1:0] corr_re_q, corr_im_q;
  logic              in_fire, push_fire, clear_fire, window_done;
  logic              out_free, out_load;

  function automatic logic signed [CORR_W-1:0] sat(input logic signed [EXT_W-1:0] v);
    logic signed [CORR_W-1:0] r;
    if (v > MAX_E) begin
      r = CORR_MAX;
    end else if (v < MIN_E) begin
      r = CORR_MIN;
    end else begin
      r = v[CORR_W-1:0];
    end
    return r;
  endfunction

  assign in_fire     = in_valid_i && (state_q == ST_IDLE);
  assign push_fire   = in_fire && (action_i == ACT_PUSH);
  assign clear_fire  = in_fire && (action_i == ACT_CLEAR);
  assign load_o      = in_fire && (action_i == ACT_LOAD);
  assign window_done = push_fire && (fill_q >= FILL_LAST);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_CALC) && (cnt_q == '0) && out_free;

  always_comb begin
    fill_d = fill_q;
    if (clear_fire) begin
      fill_d = '0;
    end else if (push_fire && (fill_q != FILL_FULL)) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (window_done) begin
          state_d = ST_CALC;
          cnt_d   = CNT_START;
        end
      end
      ST_CALC: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fill_q      <= '0;
      conj_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        conj_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      corr_re_q <= sat(EXT_W'(psum_re_i));
      corr_im_q <= sat(EXT_W'(psum_im_i));
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign cell_ctrl_o.push = push_fire;
  assign cell_ctrl_o.conj = conj_q;
  assign out_valid_o      = out_valid_q;
  assign corr_re_o        = corr_re_q;
  assign corr_im_o        = corr_im_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("fill count beyond window length");

  a_full_starts_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    window_done |=> (state_q == ST_CALC) && (cnt_q == CNT_START))
    else $error("full window did not start a correlation pass");

  a_load_full_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (fill_q == FILL_FULL))
    else $error("result loaded without a full window");

  a_load_back_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("result load did not release the input side");
`endif

endmodule

@@ sv/complex_sliding_correlator_unit.sv @@
// Complex sliding cross-correlator (matched filter).
// Input channel (in_valid_i / in_stall_o): one beat carries action_i,
// tap_index_i, value_re_i, value_im_i. A load beat writes pattern tap
// tap_index_i, a push beat shifts one Q1.15 sample into the window, a clear
// beat empties the window and keeps the pattern. Action code 3 is dropped.
// Output channel (out_valid_o / out_stall_i): one beat per push that leaves
// the window full, carrying the 40-bit saturated Q10.30 correlation
// sum(window[i] * tap[i]), oldest sample against tap 0.
// cfg_we_i / cfg_wdata_i write conjugate_pattern (taps conjugated when 1).
// Load, clear and push beats that do not complete a window are taken without
// a stall. A push that completes a window holds in_stall_o until its result is
// loaded into the output register. The result passes one product stage, then
// the partial-sum ripple through the registered cell row, one cell per cycle,
// then the output register.
// A finished result waiting on out_stall_i does not hold the input side; a
// new correlation pass waits at its end until the output register is free.
// Reset clears the fill count, the control state and conjugate_pattern;
// pattern taps are undefined until loaded.
module complex_sliding_correlator_unit #(
  parameter int unsigned PATTERN_LEN = csc_pkg::PAT_LEN_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [csc_pkg::ACT_W-1:0]          action_i,
  input  logic [csc_pkg::IDX_W-1:0]          tap_index_i,
  input  logic signed [csc_pkg::VAL_W-1:0]   value_re_i,
  input  logic signed [csc_pkg::VAL_W-1:0]   value_im_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [csc_pkg::CORR_W-1:0]  corr_re_o,
  output logic signed [csc_pkg::CORR_W-1:0]  corr_im_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_wdata_i
);
  import csc_pkg::*;

  // exact sum width of PATTERN_LEN products
  localparam int unsigned ACC_W = PROD_W + $clog2(PATTERN_LEN);

  cell_ctrl_t              cell_ctrl;
  logic                    load;
  cplx_t                   in_val;
  logic [PATTERN_LEN-1:0]  tap_we;
  cplx_t                   cell_smp  [PATTERN_LEN];
  logic signed [ACC_W-1:0] cell_psum_re [PATTERN_LEN];
  logic signed [ACC_W-1:0] cell_psum_im [PATTERN_LEN];

  assign in_val.re = value_re_i;
  assign in_val.im = value_im_i;

  csc_ctrl #(
    .PATTERN_LEN (PATTERN_LEN),
    .ACC_W       (ACC_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cell_ctrl_o (cell_ctrl),
    .load_o      (load),
    .psum_re_i   (cell_psum_re[PATTERN_LEN-1]),
    .psum_im_i   (cell_psum_im[PATTERN_LEN-1]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .corr_re_o   (corr_re_o),
    .corr_im_o   (corr_im_o)
  );

  // Cell i holds window slot i (slot 0 oldest) and tap i. Samples enter at
  // the last cell and move toward cell 0; partial sums run from cell 0 up.
  for (genvar g = 0; g < PATTERN_LEN; g++) begin : g_cell
    cplx_t                   smp_in;
    logic signed [ACC_W-1:0] psum_re_in, psum_im_in;

    // tap_index_i can only reach cells below 64; others never match
    assign tap_we[g] = load && ({{(32-IDX_W){1'b0}}, tap_index_i} == 32'(g));

    if (g == PATTERN_LEN - 1) begin : g_head
      assign smp_in = in_val;
    end else begin : g_mid
      assign smp_in = cell_smp[g+1];
    end

    if (g == 0) begin : g_first
      assign psum_re_in = '0;
      assign psum_im_in = '0;
    end else begin : g_rest
      assign psum_re_in = cell_psum_re[g-1];
      assign psum_im_in = cell_psum_im[g-1];
    end

    csc_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .tap_we_i  (tap_we[g]),
      .tap_i     (in_val),
      .smp_i     (smp_in),
      .smp_o     (cell_smp[g]),
      .psum_re_i (psum_re_in),
      .psum_im_i (psum_im_in),
      .psum_re_o (cell_psum_re[g]),
      .psum_im_o (cell_psum_im[g])
    );
  end

endmodule
